>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define SWMM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the following cycle
`define SWMM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/swmm_pkg.sv
package swmm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 3;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int DIV_STEPS = SAMPLE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_SCAN,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} swmm_state_t;

endpackage

>>> rtl/core/swmm_if.sv
interface swmm_sample_if;
	logic                              valid;
	logic                              ready;
	logic [swmm_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swmm_result_if;
	logic                              valid;
	logic                              ready;
	logic [swmm_pkg::SAMPLE_W-1:0]     scaled_value;
	logic [swmm_pkg::LEVEL_W-1:0]      display_level;

	modport source (output valid, output scaled_value, output display_level, input ready);
	modport sink   (input valid, input scaled_value, input display_level, output ready);
endinterface

>>> rtl/core/swmm_ring.sv
module swmm_ring #(
	parameter int WINDOW = 128,
	localparam int AW = $clog2(WINDOW)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [swmm_pkg::SAMPLE_W-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [swmm_pkg::SAMPLE_W-1:0] wr_data
);

	localparam int FW = $clog2(WINDOW + 1);

	logic [swmm_pkg::SAMPLE_W-1:0] mem [WINDOW];
	logic [swmm_pkg::SAMPLE_W-1:0] rd_q;
	logic [FW-1:0]                 fill_q;
	logic                          rd_hit_q;

	// entries are written in ring order from zero, so those at or above the
	// fill count are read as zero through the masked read data
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en && FW'(wr_addr) == fill_q && fill_q != FW'(WINDOW))
				fill_q <= fill_q + 1'b1;
			if (rd_en)
				rd_hit_q <= FW'(rd_addr) < fill_q;
		end
	end

	assign rd_data = rd_hit_q ? rd_q : '0;

endmodule

>>> rtl/core/swmm_div.sv
module swmm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [swmm_pkg::PROD_W-1:0]   num,
	input  logic [swmm_pkg::SAMPLE_W-1:0] den,
	output logic                          done,
	output logic [swmm_pkg::SAMPLE_W-1:0] quot
);

	localparam int W = swmm_pkg::SAMPLE_W;

	logic [W-1:0]                   rem_q;
	logic [W-1:0]                   quo_q;
	logic [swmm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [W:0]                     trial;
	logic [W:0]                     diff;
	logic                           ge;

	// restoring division, one quotient bit per cycle; the caller must keep num < den << W, the divider does not enforce it
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[swmm_pkg::PROD_W-1:W];
			quo_q <= num[W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= swmm_pkg::DIV_CNT_W'(swmm_pkg::DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == swmm_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

>>> rtl/core/sliding_window_minmax_normalizer.sv
// One sample is handled at a time: the next sample is accepted only after the scan of
// the ring through its single read port and the 16-step serial divider are through.
// The result register lets the next sample transfer while a result waits.
// Reset (arst_n low, asynchronous): ring reads as all zero, write position zero.
`include "assert_macros.svh"

module sliding_window_minmax_normalizer #(
	parameter int WINDOW = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	swmm_sample_if.sink        in_ch,
	swmm_result_if.source      out_ch
);

	localparam int AW = $clog2(WINDOW);
	localparam int W  = swmm_pkg::SAMPLE_W;

	swmm_pkg::swmm_state_t state_q, state_d;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] prev_pos;
	logic [AW-1:0] scan_addr_q;
	logic          cmp_vld_s1;
	logic [W-1:0]  sample_q;
	logic [W-1:0]  smooth_q;
	logic [W-1:0]  min_q;
	logic [W-1:0]  max_q;
	logic [W:0]    smooth_sum;
	logic [W-1:0]  smooth;
	logic [W-1:0]  offset;
	logic [swmm_pkg::PROD_W-1:0] num;
	logic [W-1:0]  span;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [W-1:0]  rd_data;
	logic          wr_en;
	logic          div_start;
	logic          div_done;
	logic [W-1:0]  quot;
	logic          in_xfer;
	logic          out_load;

	logic          out_vld_q;
	logic [W-1:0]  out_val_q;

	swmm_ring #(.WINDOW(WINDOW)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (pos_q),
		.wr_data (smooth)
	);

	swmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (span),
		.done   (div_done),
		.quot   (quot)
	);

	assign prev_pos   = (pos_q == '0) ? AW'(WINDOW - 1) : pos_q - 1'b1;
	assign smooth_sum = {1'b0, sample_q} + {1'b0, rd_data};
	assign smooth     = smooth_sum[W:1];
	// the result is (x - min) * 65535 / (max - min)
	assign offset     = smooth_q - min_q;
	assign num        = {offset, {W{1'b0}}} - {{W{1'b0}}, offset};
	assign span       = max_q - min_q;
	assign in_xfer    = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swmm_pkg::ST_IDLE:   if (in_ch.valid) state_d = swmm_pkg::ST_SMOOTH;
			swmm_pkg::ST_SMOOTH: state_d = swmm_pkg::ST_SCAN;
			swmm_pkg::ST_SCAN:   if (scan_addr_q == AW'(WINDOW - 1)) state_d = swmm_pkg::ST_DRAIN;
			swmm_pkg::ST_DRAIN:  state_d = swmm_pkg::ST_LOAD;
			swmm_pkg::ST_LOAD:   state_d = swmm_pkg::ST_DIV;
			swmm_pkg::ST_DIV:    if (div_done) state_d = swmm_pkg::ST_DONE;
			swmm_pkg::ST_DONE:   if (!out_vld_q || out_ch.ready) state_d = swmm_pkg::ST_IDLE;
			default:             state_d = swmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = scan_addr_q;
		wr_en       = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			swmm_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				rd_en       = in_ch.valid;
				rd_addr     = prev_pos;
			end
			swmm_pkg::ST_SMOOTH: wr_en = 1'b1;
			swmm_pkg::ST_SCAN:   rd_en = 1'b1;
			swmm_pkg::ST_LOAD:   div_start = 1'b1;
			swmm_pkg::ST_DONE:   out_load = !out_vld_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swmm_pkg::ST_IDLE;
			pos_q       <= '0;
			scan_addr_q <= '0;
			cmp_vld_s1  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= state_q == swmm_pkg::ST_SCAN;
			if (state_q == swmm_pkg::ST_SMOOTH) begin
				pos_q       <= (pos_q == AW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
				scan_addr_q <= '0;
			end else if (state_q == swmm_pkg::ST_SCAN) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			sample_q <= in_ch.sample;
		if (state_q == swmm_pkg::ST_SMOOTH) begin
			smooth_q <= smooth;
			min_q    <= smooth;
			max_q    <= smooth;
		end else if (cmp_vld_s1) begin
			if (rd_data < min_q)
				min_q <= rd_data;
			if (rd_data > max_q)
				max_q <= rd_data;
		end
		if (out_load)
			out_val_q <= (span == '0) ? '0 : quot;
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.scaled_value  = out_val_q;
	assign out_ch.display_level = out_val_q[W-1 -: swmm_pkg::LEVEL_W];

	`SWMM_ASSERT_NXT(a_xfer_starts, in_xfer, state_q == swmm_pkg::ST_SMOOTH, "transfer did not start item")
	`SWMM_ASSERT_IMP(a_div_in_div, div_done, state_q == swmm_pkg::ST_DIV, "divider done outside divide")
	`SWMM_ASSERT_IMP(a_scan_range, state_q == swmm_pkg::ST_SCAN, scan_addr_q <= AW'(WINDOW - 1), "scan past ring end")
	`SWMM_ASSERT_IMP(a_ready_idle, in_ch.ready, state_q == swmm_pkg::ST_IDLE && !cmp_vld_s1, "ready while busy")

endmodule
